FILE: hdl/lobm_pkg.sv
// types and constants shared by the order book matcher
// no dependencies

package lobm_pkg;

   localparam int PRICE_W = 32;
   localparam int QTY_W   = 24;
   localparam int IDENT_W = 32;
   localparam int TOTQ_W  = 48;
   localparam int TOTN_W  = 64;
   localparam int FILL_W  = 32;
   localparam int IVL_W   = 16;

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   // one resting order
   typedef struct packed {
      logic               valid;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
      logic [IDENT_W-1:0] ident;
   } entry_type;

   // command broadcast from the control to every book cell
   typedef struct packed {
      logic               pop;     // shift towards slot 0, dropping slot 0
      logic               insert;  // insert the broadcast entry in priority order
      logic               upd_head;
      logic [QTY_W-1:0]   head_qty;
      logic               is_bid;
      entry_type          ins;
   } book_cmd_type;

endpackage

FILE: hdl/limit_order_book_matcher.sv
// top level of the limit order book matcher: control, totals and two books
// depends on lobm_pkg and lobm_book
//
//  channel | direction | word
//  req_    | in        | side, limit_price, share_quantity, order_id
//  rsp_    | out       | one trade or one no-trade report, last marks the end
//  csr_    | in        | sample_interval
//
// an order is accepted, then each trade takes a match step and a step that adds
// the product into the notional, then one more match finds no further trade,
// one step rests the remainder and one launches the last word.
// the 24 x 32 multiply for the notional is registered between those two trade steps.
// a sample_interval write, or a wrap of the fill count, adds a serial remainder of the fill count by the interval.
// synchronous active-high reset empties both books and clears the totals.
// a stalled rsp_ holds the sequencer; req_ is taken only while idle.

module limit_order_book_matcher
   import lobm_pkg::*;
#(
   parameter int BOOK_DEPTH = 32
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_side,
   input  logic [PRICE_W-1:0] req_limit_price,
   input  logic [QTY_W-1:0]   req_share_quantity,
   input  logic [IDENT_W-1:0] req_order_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_trade_valid,
   output logic [PRICE_W-1:0] rsp_trade_price,
   output logic [QTY_W-1:0]   rsp_trade_quantity,
   output logic [IDENT_W-1:0] rsp_buyer_id,
   output logic [IDENT_W-1:0] rsp_seller_id,
   output logic               rsp_sampled,
   output logic               rsp_last,
   output logic               rsp_status,
   output logic [TOTQ_W-1:0]  rsp_running_quantity,
   output logic [TOTN_W-1:0]  rsp_running_notional,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [IVL_W-1:0]   csr_sample_interval
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MATCH = 3'd1;
   localparam logic [2:0] ST_ACCUM = 3'd2;
   localparam logic [2:0] ST_REST  = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;
   localparam logic [2:0] ST_MOD   = 3'd5;
   localparam logic [5:0] MAX_TRADES = 6'd32;

   logic [2:0]         state_ff, state_in;
   logic               side_ff;
   logic [PRICE_W-1:0] price_ff;
   logic [QTY_W-1:0]   rem_ff, rem_in;
   logic [IDENT_W-1:0] id_ff;
   logic [5:0]         ntrade_ff, ntrade_in;
   logic [IVL_W-1:0]   ivl_ff;
   logic [IVL_W-1:0]   phase_ff, phase_in;   // fill_count modulo interval
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               fwrap_ff, fwrap_in;
   logic [TOTQ_W-1:0]  totq_ff, totq_in;
   logic [TOTN_W-1:0]  totn_ff, totn_in;
   logic [TOTN_W-1:0]  prod_ff, prod_in;
   logic               ovalid_ff, ovalid_in;
   logic               otv_ff, osamp_ff, olast_ff, ostat_ff;
   logic [PRICE_W-1:0] oprice_ff;
   logic [QTY_W-1:0]   oqty_ff;
   logic [IDENT_W-1:0] obuy_ff, osell_ff;
   logic               otv_in, osamp_in, olast_in, ostat_in;
   logic [PRICE_W-1:0] oprice_in;
   logic [QTY_W-1:0]   oqty_in;
   logic [IDENT_W-1:0] obuy_in, osell_in;
   logic [IVL_W-1:0]   mrem_ff, mrem_in, mrem_next;
   logic [FILL_W-1:0]  mdiv_ff, mdiv_in;
   logic [4:0]         mcnt_ff, mcnt_in;
   logic [2:0]         mret_ff, mret_in;

   book_cmd_type bid_cmd, ask_cmd;
   entry_type    bid_head, ask_head, opp;
   logic         bid_full, ask_full;

   lobm_book #(.Depth(BOOK_DEPTH)) u_bids (
      .clock(clock), .reset(reset), .cmd(bid_cmd), .head(bid_head), .full(bid_full));
   lobm_book #(.Depth(BOOK_DEPTH)) u_asks (
      .clock(clock), .reset(reset), .cmd(ask_cmd), .head(ask_head), .full(ask_full));

   logic                     crosses, rest_full, more;
   logic [QTY_W-1:0]         tq, rq_left, rem_left;
   logic [PRICE_W-1:0]       tp;
   logic [QTY_W+PRICE_W-1:0] tprod;
   logic [IVL_W-1:0]         ivl, ph1, ph2;
   logic [1:0]               nfill;
   logic [FILL_W:0]          fsum;
   logic [IVL_W:0]           mshift;
   logic                     out_free;

   assign opp      = side_ff ? bid_head : ask_head;
   assign crosses  = opp.valid && (side_ff ? (opp.price >= price_ff) : (price_ff >= opp.price));
   assign more     = (rem_ff != '0) && (ntrade_ff != MAX_TRADES) && crosses;
   assign tq       = (opp.qty < rem_ff) ? opp.qty : rem_ff;
   // a trade always executes at the sell order's price
   assign tp       = side_ff ? price_ff : opp.price;
   assign tprod    = (QTY_W+PRICE_W)'(tq) * (QTY_W+PRICE_W)'(tp);
   assign rq_left  = opp.qty - tq;
   assign rem_left = rem_ff - tq;
   assign nfill    = {1'b0, rq_left == '0} + {1'b0, rem_left == '0};
   assign fsum     = {1'b0, fill_ff} + {{(FILL_W-1){1'b0}}, nfill};
   assign ivl      = (ivl_ff == '0) ? IVL_W'(1) : ivl_ff;
   assign rest_full = side_ff ? ask_full : bid_full;
   assign out_free = !ovalid_ff || rsp_ready;

   // one restoring step of fill_count modulo interval, msb first
   assign mshift    = {mrem_ff, mdiv_ff[FILL_W-1]};
   assign mrem_next = (mshift >= {1'b0, ivl}) ? IVL_W'(mshift - {1'b0, ivl})
                                              : mshift[IVL_W-1:0];

   // phase advance by one fill and by two fills, wrapping at the interval
   always_comb begin
      ph1 = (phase_ff + IVL_W'(1) == ivl) ? '0 : phase_ff + IVL_W'(1);
      ph2 = (ph1 + IVL_W'(1) == ivl) ? '0 : ph1 + IVL_W'(1);
   end

   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      ntrade_in    = ntrade_ff;
      phase_in     = phase_ff;
      fill_in      = fill_ff;
      fwrap_in     = fwrap_ff;
      totq_in      = totq_ff;
      totn_in      = totn_ff;
      prod_in      = prod_ff;
      mrem_in      = mrem_ff;
      mdiv_in      = mdiv_ff;
      mcnt_in      = mcnt_ff;
      mret_in      = mret_ff;
      ovalid_in    = ovalid_ff && !rsp_ready;
      otv_in = otv_ff; oprice_in = oprice_ff; oqty_in = oqty_ff;
      obuy_in = obuy_ff; osell_in = osell_ff; osamp_in = osamp_ff;
      olast_in = olast_ff; ostat_in = ostat_ff;
      bid_cmd = '0;
      ask_cmd = '0;
      bid_cmd.is_bid = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid && csr_ready) begin
               mrem_in  = '0;
               mdiv_in  = fill_ff;
               mcnt_in  = '0;
               mret_in  = ST_IDLE;
               state_in = ST_MOD;
            end else if (req_valid && req_ready) begin
               rem_in    = req_share_quantity;
               ntrade_in = '0;
               state_in  = ST_MATCH;
            end
         end
         ST_MATCH: begin
            if (more) begin
               if (out_free) begin
                  prod_in   = TOTN_W'(tprod);
                  totq_in   = totq_ff + TOTQ_W'(tq);
                  osamp_in  = (phase_ff == '0);
                  phase_in  = (nfill == 2'd2) ? ph2 : (nfill == 2'd1) ? ph1 : phase_ff;
                  fill_in   = fsum[FILL_W-1:0];
                  fwrap_in  = fsum[FILL_W];
                  rem_in    = rem_left;
                  ntrade_in = ntrade_ff + 6'd1;
                  otv_in    = 1'b1;
                  oprice_in = tp;
                  oqty_in   = tq;
                  obuy_in   = side_ff ? opp.ident : id_ff;
                  osell_in  = side_ff ? id_ff : opp.ident;
                  if (side_ff) begin
                     bid_cmd.pop = (rq_left == '0);
                     bid_cmd.upd_head = 1'b1;
                     bid_cmd.head_qty = rq_left;
                  end else begin
                     ask_cmd.pop = (rq_left == '0);
                     ask_cmd.upd_head = 1'b1;
                     ask_cmd.head_qty = rq_left;
                  end
                  state_in = ST_ACCUM;
               end
            end else begin
               state_in = ST_REST;
            end
         end
         ST_ACCUM: begin
            // the book head is settled here, so a word with another trade behind it goes now
            totn_in = totn_ff + prod_ff;
            if (more) ovalid_in = 1'b1;
            olast_in = 1'b0;
            ostat_in = 1'b0;
            fwrap_in = 1'b0;
            if (fwrap_ff) begin
               mrem_in  = '0;
               mdiv_in  = fill_ff;
               mcnt_in  = '0;
               mret_in  = ST_MATCH;
               state_in = ST_MOD;
            end else begin
               state_in = ST_MATCH;
            end
         end
         ST_REST: begin
            if (out_free) begin
               if (rem_ff != '0 && !rest_full) begin
                  if (side_ff) begin
                     ask_cmd.insert = 1'b1;
                     ask_cmd.ins = '{1'b1, price_ff, rem_ff, id_ff};
                  end else begin
                     bid_cmd.insert = 1'b1;
                     bid_cmd.ins = '{1'b1, price_ff, rem_ff, id_ff};
                  end
               end
               ostat_in = (rem_ff != '0) && rest_full;
               olast_in = 1'b1;
               if (ntrade_ff == '0) begin
                  otv_in = 1'b0; oprice_in = '0; oqty_in = '0;
                  obuy_in = '0; osell_in = '0; osamp_in = 1'b0;
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               ovalid_in    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_MOD: begin
            mrem_in = mrem_next;
            mdiv_in = mdiv_ff << 1;
            mcnt_in = mcnt_ff + 5'd1;
            if (mcnt_ff == 5'd31) begin
               phase_in = mrem_next;
               state_in = mret_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ivl_ff       <= IVL_W'(1);
         phase_ff     <= '0;
         fill_ff      <= '0;
         fwrap_ff     <= 1'b0;
         totq_ff      <= '0;
         totn_ff      <= '0;
         ovalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_valid && csr_ready) ivl_ff <= csr_sample_interval;
         phase_ff     <= phase_in;
         fill_ff      <= fill_in;
         fwrap_ff     <= fwrap_in;
         totq_ff      <= totq_in;
         totn_ff      <= totn_in;
         ovalid_ff    <= ovalid_in;
      end
      if (req_valid && req_ready) begin
         side_ff  <= req_side;
         price_ff <= req_limit_price;
         id_ff    <= req_order_id;
      end
      rem_ff    <= rem_in;
      ntrade_ff <= ntrade_in;
      prod_ff   <= prod_in;
      mrem_ff   <= mrem_in;
      mdiv_ff   <= mdiv_in;
      mcnt_ff   <= mcnt_in;
      mret_ff   <= mret_in;
      otv_ff <= otv_in; oprice_ff <= oprice_in; oqty_ff <= oqty_in;
      obuy_ff <= obuy_in; osell_ff <= osell_in; osamp_ff <= osamp_in;
      olast_ff <= olast_in; ostat_ff <= ostat_in;
   end

   // totals only reach the port once the word goes out
   logic [TOTQ_W-1:0] rq_ff;
   logic [TOTN_W-1:0] rn_ff;
   always_ff @(posedge clock) begin
      if (ovalid_in && !(ovalid_ff && !rsp_ready)) begin
         rq_ff <= totq_ff;
         rn_ff <= totn_in;
      end
   end

   assign rsp_valid            = ovalid_ff;
   assign rsp_trade_valid      = otv_ff;
   assign rsp_trade_price      = oprice_ff;
   assign rsp_trade_quantity   = oqty_ff;
   assign rsp_buyer_id         = obuy_ff;
   assign rsp_seller_id        = osell_ff;
   assign rsp_sampled          = osamp_ff;
   assign rsp_last             = olast_ff;
   assign rsp_status           = ostat_ff;
   assign rsp_running_quantity = rq_ff;
   assign rsp_running_notional = rn_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_last)
      else $error("new order taken while a trade word is outstanding");
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last)
      else $error("status set on a word that is not last");
   a_notrade_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_trade_valid |-> rsp_last && rsp_trade_quantity == '0)
      else $error("no-trade word malformed");
   a_accept_match: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_MATCH)
      else $error("accepted order did not start matching");

endmodule

FILE: hdl/lobm_cell.sv
// one slot of a sorted order book, exchanging entries with its neighbours
// depends on lobm_pkg

module lobm_cell
   import lobm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  book_cmd_type cmd,
   input  entry_type    prev_entry,   // slot below (towards the head)
   input  logic         prev_place,   // insert point lies at or below the slot below
   input  entry_type    next_entry,   // slot above
   input  logic         is_head,
   output entry_type    entry,
   output logic         place         // insert point lies at or below this slot
);

   entry_type entry_ff, entry_in;
   logic      ranks;

   // the new order goes ahead of this one when it strictly beats it
   always_comb begin
      if (cmd.is_bid) ranks = cmd.ins.price > entry_ff.price;
      else            ranks = cmd.ins.price < entry_ff.price;
   end

   assign place = prev_place || !entry_ff.valid || ranks;

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.pop) begin
         entry_in = next_entry;
      end else if (cmd.insert) begin
         if (prev_place)  entry_in = prev_entry;
         else if (place)  entry_in = cmd.ins;
      end else if (cmd.upd_head && is_head) begin
         entry_in.qty = cmd.head_qty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) entry_ff.valid <= 1'b0;
      else       entry_ff.valid <= entry_in.valid;
      entry_ff.price <= entry_in.price;
      entry_ff.qty   <= entry_in.qty;
      entry_ff.ident <= entry_in.ident;
   end

   assign entry = entry_ff;

endmodule

FILE: hdl/lobm_book.sv
// a chain of book cells holding one side of the book, best order in slot 0
// depends on lobm_pkg and lobm_cell

module lobm_book
   import lobm_pkg::*;
#(
   parameter int Depth = 32
)(
   input  logic         clock,
   input  logic         reset,
   input  book_cmd_type cmd,
   output entry_type    head,
   output logic         full
);

   entry_type ents [Depth];
   logic      plc  [Depth];

   for (genvar i = 0; i < Depth; i++) begin : g_cell
      entry_type pe, ne;
      logic      pp;
      if (i == 0) begin : g_first
         assign pe = '0;
         assign pp = 1'b0;
      end else begin : g_mid
         assign pe = ents[i-1];
         assign pp = plc[i-1];
      end
      if (i == Depth-1) begin : g_last
         assign ne = '0;
      end else begin : g_up
         assign ne = ents[i+1];
      end
      lobm_cell u_cell (
         .clock(clock), .reset(reset), .cmd(cmd),
         .prev_entry(pe), .prev_place(pp), .next_entry(ne),
         .is_head(i == 0), .entry(ents[i]), .place(plc[i])
      );
   end

   assign head = ents[0];
   assign full = ents[Depth-1].valid;

endmodule

FILE: dv/limit_order_book_matcher_tb.sv
// self-checking bench for limit_order_book_matcher: directed table, then random order flow
// depends on lobm_pkg and the limit_order_book_matcher rtl only

module limit_order_book_matcher_tb
   import lobm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = 32;
   localparam int MAX_TRADES = 32;
   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_OFF   = 300;
   localparam int SIDE_BID   = 0;
   localparam int SIDE_ASK   = 1;

   typedef struct packed {
      logic               side;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
      logic [IDENT_W-1:0] ident;
   } order_type;

   typedef struct packed {
      logic               traded;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
      logic [IDENT_W-1:0] buyer;
      logic [IDENT_W-1:0] seller;
      logic               sampled;
      logic               last;
      logic               status;
      logic [TOTQ_W-1:0]  run_qty;
      logic [TOTN_W-1:0]  run_notional;
   } report_type;

   // typed rows expect a bare no-trade report with zero totals
   typedef struct {
      order_type ord;
      bit        typed;
   } row_type;

   typedef struct {
      logic [IVL_W-1:0] interval;
      int               send_idle;
      int               recv_idle;
      int               build_pct;
      int               items;
      bit               squeeze;
   } phase_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_side = 1'b0;
   logic [PRICE_W-1:0] req_limit_price = '0;
   logic [QTY_W-1:0]   req_share_quantity = '0;
   logic [IDENT_W-1:0] req_order_id = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_trade_valid;
   logic [PRICE_W-1:0] rsp_trade_price;
   logic [QTY_W-1:0]   rsp_trade_quantity;
   logic [IDENT_W-1:0] rsp_buyer_id;
   logic [IDENT_W-1:0] rsp_seller_id;
   logic               rsp_sampled;
   logic               rsp_last;
   logic               rsp_status;
   logic [TOTQ_W-1:0]  rsp_running_quantity;
   logic [TOTN_W-1:0]  rsp_running_notional;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [IVL_W-1:0]   csr_sample_interval = '0;

   limit_order_book_matcher #(.BOOK_DEPTH(DEPTH)) dut (.*);

   // predictor state
   logic [PRICE_W-1:0] book_price [2][DEPTH];
   logic [QTY_W-1:0]   book_qty   [2][DEPTH];
   logic [IDENT_W-1:0] book_ident [2][DEPTH];
   int                 book_len   [2] = '{0, 0};
   logic [TOTQ_W-1:0]  traded_qty = '0;
   logic [TOTN_W-1:0]  traded_notional = '0;
   logic [FILL_W-1:0]  fills_done = '0;
   logic [IVL_W-1:0]   interval_now = 16'd1;

   report_type trades_due[$];
   int  send_idle = 0, recv_idle = 0;
   bit  squeeze_now = 1'b0;
   int  mismatches = 0, orders_sent = 0, trades_seen = 0, quiet_seen = 0, drops_seen = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic book_pop(input int s);
      for (int i = 0; i + 1 < book_len[s]; i++) begin
         book_price[s][i] = book_price[s][i+1];
         book_qty[s][i]   = book_qty[s][i+1];
         book_ident[s][i] = book_ident[s][i+1];
      end
      book_len[s]--;
   endtask

   task automatic book_rest(input int s, input order_type o, input logic [QTY_W-1:0] rem,
                            output bit full);
      int pos;
      pos = 0;
      full = (book_len[s] >= DEPTH);
      if (!full) begin
         // equal prices keep arrival order
         while (pos < book_len[s] && (s == SIDE_BID ? book_price[s][pos] >= o.price
                                                    : book_price[s][pos] <= o.price))
            pos++;
         for (int i = book_len[s]; i > pos; i--) begin
            book_price[s][i] = book_price[s][i-1];
            book_qty[s][i]   = book_qty[s][i-1];
            book_ident[s][i] = book_ident[s][i-1];
         end
         book_price[s][pos] = o.price;
         book_qty[s][pos]   = rem;
         book_ident[s][pos] = o.ident;
         book_len[s]++;
      end
   endtask

   task automatic match_order(input order_type o, output report_type res[$]);
      logic [QTY_W-1:0]   rem, rq, tq;
      logic [PRICE_W-1:0] tp;
      logic [FILL_W-1:0]  ivl;
      report_type         r;
      int                 opp;
      bit                 full, buy_done, sell_done;
      res = {};
      rem = o.qty;
      full = 1'b0;
      ivl = (interval_now == 0) ? 32'd1 : FILL_W'(interval_now);
      opp = (o.side == SIDE_BUY) ? SIDE_ASK : SIDE_BID;
      while (rem > 0 && res.size() < MAX_TRADES) begin
         if (book_len[opp] == 0) break;
         if (o.side == SIDE_BUY && o.price < book_price[opp][0]) break;
         if (o.side == SIDE_SELL && book_price[opp][0] < o.price) break;
         r = '0;
         rq = book_qty[opp][0];
         tp = (o.side == SIDE_BUY) ? book_price[opp][0] : o.price;
         r.buyer  = (o.side == SIDE_BUY) ? o.ident : book_ident[opp][0];
         r.seller = (o.side == SIDE_BUY) ? book_ident[opp][0] : o.ident;
         tq = (rq < rem) ? rq : rem;
         traded_qty = traded_qty + TOTQ_W'(tq);
         traded_notional = traded_notional + TOTN_W'(tq) * TOTN_W'(tp);
         r.sampled = (fills_done % ivl) == 0;
         rem = rem - tq;
         rq = rq - tq;
         buy_done  = (o.side == SIDE_SELL) ? (rq == 0) : (rem == 0);
         sell_done = (o.side == SIDE_SELL) ? (rem == 0) : (rq == 0);
         fills_done = fills_done + buy_done + sell_done;
         book_qty[opp][0] = rq;
         if (rq == 0) book_pop(opp);
         r.traded = 1'b1;
         r.price = tp;
         r.qty = tq;
         r.run_qty = traded_qty;
         r.run_notional = traded_notional;
         res = {res, r};
      end
      if (rem > 0) book_rest((o.side == SIDE_BUY) ? SIDE_BID : SIDE_ASK, o, rem, full);
      if (res.size() == 0) begin
         r = '0;
         r.run_qty = traded_qty;
         r.run_notional = traded_notional;
         res = {res, r};
      end
      res[res.size()-1].last = 1'b1;
      res[res.size()-1].status = full;
   endtask

   task automatic send_order(input order_type o, input bit typed);
      report_type res[$];
      report_type plain;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_side           <= o.side;
      req_limit_price    <= o.price;
      req_share_quantity <= o.qty;
      req_order_id       <= o.ident;
      do @(posedge clock); while (!req_ready);
      orders_sent++;
      match_order(o, res);
      if (typed) begin
         plain = '0;
         plain.last = 1'b1;
         trades_due = {trades_due, plain};
      end else begin
         foreach (res[i]) trades_due = {trades_due, res[i]};
      end
   endtask

   task automatic write_interval(input logic [IVL_W-1:0] v);
      req_valid <= 1'b0;
      while (trades_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_sample_interval <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      interval_now = v;
   endtask

   function automatic order_type next_order(input int build_pct);
      order_type o;
      int        r;
      r = $urandom_range(99);
      o.side  = 1'($urandom_range(1));
      o.ident = $urandom;
      o.qty   = QTY_W'($urandom_range(60, 1));
      if (r < 4) begin
         // sweep the opposite book at an extreme price
         o.price = (o.side == SIDE_BUY) ? '1 : '0;
         o.qty   = '1;
      end else if (r < 7) begin
         o.price = $urandom;
         o.qty   = '0;
      end else if (r < 12) begin
         o.price = $urandom;
         o.qty   = QTY_W'($urandom);
      end else if (r < 12 + build_pct) begin
         o.price = (o.side == SIDE_BUY) ? $urandom_range(199, 100) : $urandom_range(10099, 10000);
         o.qty   = QTY_W'($urandom_range(200, 1));
      end else begin
         o.price = $urandom_range(1020, 980);
      end
      return o;
   endfunction

   // result side: check, then choose the stall for the next cycle
   initial begin
      report_type got, want;
      int         hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_trade_valid, rsp_trade_price, rsp_trade_quantity, rsp_buyer_id,
                    rsp_seller_id, rsp_sampled, rsp_last, rsp_status, rsp_running_quantity,
                    rsp_running_notional};
            if (got.traded) trades_seen++; else quiet_seen++;
            if (got.status) drops_seen++;
            if (trades_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word %p", got);
            end else begin
               want = trades_due.pop_front();
               if (got.traded !== want.traded || got.price !== want.price ||
                   got.qty !== want.qty || got.buyer !== want.buyer ||
                   got.seller !== want.seller || got.sampled !== want.sampled ||
                   got.last !== want.last || got.status !== want.status ||
                   got.run_qty !== want.run_qty || got.run_notional !== want.run_notional) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
               end
            end
         end
         if (squeeze_now) begin
            squeeze_now = 1'b0;
            hold = HOLD_OFF;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // watchdog on cycles where no handshake completes
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d words outstanding", trades_due.size());
            $display("limit_order_book_matcher verification failed");
            $finish;
         end
      end
   end

   initial begin
      row_type   rows[$];
      phase_type phases[$];
      rows = '{
         '{'{SIDE_BUY,  32'd100, 24'd10, 32'd1}, 1'b1},
         '{'{SIDE_SELL, 32'd0,   24'd0,  32'd2}, 1'b1},
         '{'{SIDE_SELL, 32'd90,  24'd4,  32'd3}, 1'b0},
         '{'{SIDE_SELL, 32'd100, 24'd10, 32'd4}, 1'b0},
         '{'{SIDE_BUY,  '1,      '1,     '1},    1'b0},
         '{'{SIDE_SELL, '0,      '1,     '0},    1'b0},
         '{'{SIDE_BUY,  32'd50,  24'd5,  32'd10}, 1'b0},
         '{'{SIDE_BUY,  32'd50,  24'd5,  32'd11}, 1'b0},
         '{'{SIDE_BUY,  32'd60,  24'd3,  32'd12}, 1'b0},
         '{'{SIDE_SELL, 32'd50,  24'd12, 32'd13}, 1'b0},
         '{'{SIDE_SELL, 32'd70,  24'd8,  32'd20}, 1'b0},
         '{'{SIDE_SELL, 32'd70,  24'd8,  32'd21}, 1'b0},
         '{'{SIDE_SELL, 32'd65,  24'd2,  32'd22}, 1'b0},
         '{'{SIDE_BUY,  32'd70,  24'd20, 32'd23}, 1'b0},
         '{'{SIDE_BUY,  32'd49,  24'd0,  32'd24}, 1'b0},
         '{'{SIDE_SELL, 32'd49,  24'd1,  32'd25}, 1'b0},
         '{'{SIDE_BUY,  '1,      24'd1,  32'h5555_aaaa}, 1'b0}
      };
      phases = '{
         '{16'd1,     0,  0,  20, 50, 1'b0},
         '{16'd0,     56, 0,  20, 50, 1'b0},
         '{16'd65535, 0,  56, 20, 50, 1'b0},
         '{16'd3,     16, 16, 30, 50, 1'b0},
         '{16'd2,     0,  0,  80, 60, 1'b1}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_interval(16'd1);
      foreach (rows[i]) send_order(rows[i].ord, rows[i].typed);
      foreach (phases[p]) begin
         write_interval(phases[p].interval);
         send_idle = phases[p].send_idle;
         recv_idle = phases[p].recv_idle;
         // stall the result side while the order stream keeps coming
         if (phases[p].squeeze) squeeze_now = 1'b1;
         for (int k = 0; k < phases[p].items; k++)
            send_order(next_order(phases[p].build_pct), 1'b0);
      end
      req_valid <= 1'b0;
      recv_idle = 0;
      while (trades_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("%0d orders, %0d trades, %0d no-trade reports, %0d book-full drops",
               orders_sent, trades_seen, quiet_seen, drops_seen);
      $display("sample intervals 1, 0, 65535, 3, 2; %0d mismatches", mismatches);
      if (mismatches == 0)
         $display("limit_order_book_matcher verification clean");
      else
         $display("limit_order_book_matcher verification failed");
      $finish;
   end

endmodule

FILE: files.f
hdl/lobm_pkg.sv
hdl/lobm_cell.sv
hdl/lobm_book.sv
hdl/limit_order_book_matcher.sv
dv/limit_order_book_matcher_tb.sv
